### design/tmc_pkg.sv
// tmc_pkg: constants, widths, codes and the controller state type for the
// template match classifier. No dependencies.
`default_nettype none

package tmc_pkg;

  // Sizing
  localparam int GESTURES              = 5;
  localparam int TEMPLATES_PER_GESTURE = 3;
  localparam int CHANNELS              = 15;
  localparam int SAMPLE_BITS           = 8;

  localparam int NUM_TEMPLATES = GESTURES * TEMPLATES_PER_GESTURE;
  localparam int TMPL_DEPTH    = NUM_TEMPLATES * CHANNELS;

  // Field widths of the transactions
  localparam int FUNC_W    = 1;
  localparam int GESTURE_W = 3;
  localparam int SLOT_W    = 2;
  localparam int CHAN_W    = 4;
  localparam int VALUE_W   = 8;
  localparam int ACC_W     = 20;
  localparam int THR_W     = 10;
  localparam int THR_SQ_W  = 2 * THR_W;

  // Derived internal widths
  localparam int TA_W   = (TMPL_DEPTH > 1) ? $clog2(TMPL_DEPTH) : 1;
  localparam int TCNT_W = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
  localparam int SCNT_W = (TEMPLATES_PER_GESTURE > 1) ? $clog2(TEMPLATES_PER_GESTURE) : 1;
  localparam int GCNT_W = (GESTURES > 1) ? $clog2(GESTURES) : 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;

  // Values
  localparam logic [ACC_W-1:0] ACC_MAX       = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] START_BEST_SQ = ACC_W'(1000000);
  localparam int               THR_RESET     = 100;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } tmc_state_t;

endpackage

`default_nettype wire

### design/tmc_in_if.sv
// tmc_in_if: valid/ready channel carrying load and classify transactions.
// Depends on tmc_pkg for field widths.
`default_nettype none

interface tmc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tmc_pkg::FUNC_W-1:0]     func;
  logic [tmc_pkg::GESTURE_W-1:0]  gesture_index;
  logic [tmc_pkg::SLOT_W-1:0]     slot_index;
  logic [tmc_pkg::CHAN_W-1:0]     channel_index;
  logic [tmc_pkg::VALUE_W-1:0]    sensor_value;
  logic                           last_channel;

  modport source (output valid, func, gesture_index, slot_index, channel_index,
                  sensor_value, last_channel, input ready);
  modport sink   (input valid, func, gesture_index, slot_index, channel_index,
                  sensor_value, last_channel, output ready);
endinterface

`default_nettype wire

### design/tmc_out_if.sv
// tmc_out_if: valid/ready channel carrying classification results.
// Depends on tmc_pkg for field widths.
`default_nettype none

interface tmc_out_if;
  logic                           valid;
  logic                           ready;
  logic [tmc_pkg::GESTURE_W-1:0]  gesture_id;
  logic                           matched;
  logic [tmc_pkg::ACC_W-1:0]      best_distance_sq;

  modport source (output valid, gesture_id, matched, best_distance_sq, input ready);
  modport sink   (input valid, gesture_id, matched, best_distance_sq, output ready);
endinterface

`default_nettype wire

### design/template_match_classifier.sv
// template_match_classifier: nearest-template classifier, top level (tmc_pkg, tmc_in_if,
//   tmc_out_if, tmc_ram). Reset: rst_n synchronous, active low; sums read as zero,
//   threshold 100, template RAM not cleared.
// Classify sample: one template per cycle through the accumulator RAM, then the two-stage pipeline
//   drains. Last-channel sample: the result is registered after the drain, next input taken after
//   that; a result left waiting at the output stalls the next result, and so further input,
//   until it is taken.
`default_nettype none

module template_match_classifier (
  input  wire                          clk,
  input  wire                          rst_n,
  tmc_in_if.sink                       in_ch,
  tmc_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [tmc_pkg::THR_W-1:0]     cfg_wdata
);

  // ------------------------------------------------------------------------
  // Control state
  // ------------------------------------------------------------------------
  tmc_pkg::tmc_state_t state_r, state_nxt;

  logic [tmc_pkg::TCNT_W-1:0]      cnt_r, cnt_nxt;     // template being issued
  logic [tmc_pkg::SCNT_W-1:0]      scnt_r, scnt_nxt;   // slot within gesture
  logic [tmc_pkg::GCNT_W-1:0]      gcnt_r, gcnt_nxt;   // gesture of issued template
  logic [tmc_pkg::TA_W-1:0]        base_r, base_nxt;   // template RAM read address

  // Latched classify transaction
  logic [tmc_pkg::SAMPLE_BITS-1:0] val_r;
  logic                            in_rng_r;
  logic                            last_r;

  // Threshold kept squared, so the final compare needs no multiplier
  logic [tmc_pkg::THR_SQ_W-1:0]    thr_sq_r;

  // Pipeline: issue -> p1 (RAM data back, square) -> p2 (add, write back)
  logic                            p1_v_r, p2_v_r;
  logic [tmc_pkg::TCNT_W-1:0]      p1_t_r, p2_t_r;
  logic [tmc_pkg::GCNT_W-1:0]      p1_g_r, p2_g_r;
  logic [tmc_pkg::SQ_W-1:0]        sq_r;
  logic [tmc_pkg::ACC_W-1:0]       accq_r;

  // One valid bit per accumulator: a clear entry reads as zero
  logic [tmc_pkg::NUM_TEMPLATES-1:0] acc_vld_r;

  // Running minimum over the frame
  logic [tmc_pkg::ACC_W-1:0]       best_r;
  logic [tmc_pkg::GCNT_W-1:0]      best_g_r;
  logic                            found_r;

  // Output register
  logic                            out_valid_r;
  logic [tmc_pkg::GESTURE_W-1:0]   out_gid_r;
  logic                            out_matched_r;
  logic [tmc_pkg::ACC_W-1:0]       out_best_r;

  // ------------------------------------------------------------------------
  // Input decode
  // ------------------------------------------------------------------------
  logic in_acc, load_ok, cls_start, chan_ok, issue, out_ld;

  assign in_ch.ready = (state_r == tmc_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign chan_ok     = (int'(in_ch.channel_index) < tmc_pkg::CHANNELS);
  // Out-of-range load indices drop the write
  assign load_ok     = (in_ch.func == tmc_pkg::FUNC_LOAD)
                    && (int'(in_ch.gesture_index) < tmc_pkg::GESTURES)
                    && (int'(in_ch.slot_index) < tmc_pkg::TEMPLATES_PER_GESTURE)
                    && chan_ok;
  assign cls_start   = in_acc && (in_ch.func == tmc_pkg::FUNC_CLASSIFY);
  assign issue       = (state_r == tmc_pkg::ST_RUN);
  assign out_ld      = (state_r == tmc_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);

  // ------------------------------------------------------------------------
  // Template RAM: row per template, CHANNELS entries per row
  // ------------------------------------------------------------------------
  logic                            tm_we;
  logic [tmc_pkg::TA_W-1:0]        tm_waddr;
  logic [tmc_pkg::SAMPLE_BITS-1:0] tm_rdata;

  assign tm_we    = in_acc && load_ok;
  assign tm_waddr = tmc_pkg::TA_W'((int'(in_ch.gesture_index) * tmc_pkg::TEMPLATES_PER_GESTURE
                                   + int'(in_ch.slot_index)) * tmc_pkg::CHANNELS
                                   + int'(in_ch.channel_index));

  tmc_ram #(
    .WIDTH (tmc_pkg::SAMPLE_BITS),
    .DEPTH (tmc_pkg::TMPL_DEPTH)
  ) u_tmpl_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (in_ch.sensor_value[tmc_pkg::SAMPLE_BITS-1:0]),
    .raddr (base_r),
    .rdata (tm_rdata)
  );

  // ------------------------------------------------------------------------
  // Accumulator RAM: read in issue, written back from p2.
  // Each sample touches every template once, and the next transaction is
  // only taken once the pipeline has drained, so no entry is read while a
  // write to it is still in flight.
  // ------------------------------------------------------------------------
  logic [tmc_pkg::ACC_W-1:0] acc_rdata, acc_wdata;

  tmc_ram #(
    .WIDTH (tmc_pkg::ACC_W),
    .DEPTH (tmc_pkg::NUM_TEMPLATES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (p2_v_r),
    .waddr (p2_t_r),
    .wdata (acc_wdata),
    .raddr (cnt_r),
    .rdata (acc_rdata)
  );

  // p1: absolute difference and square (channel out of range adds nothing)
  logic [tmc_pkg::SAMPLE_BITS-1:0] diff;
  logic [tmc_pkg::SQ_W-1:0]        sq_nxt;
  logic [tmc_pkg::ACC_W-1:0]       accq_nxt;

  always_comb begin
    diff     = (val_r > tm_rdata) ? (val_r - tm_rdata) : (tm_rdata - val_r);
    sq_nxt   = in_rng_r ? (tmc_pkg::SQ_W'(diff) * tmc_pkg::SQ_W'(diff)) : '0;
    accq_nxt = acc_vld_r[p1_t_r] ? acc_rdata : '0;
  end

  // p2: saturating add
  logic [tmc_pkg::SUM_W-1:0] sum_full;
  logic                      better;

  always_comb begin
    sum_full  = tmc_pkg::SUM_W'(accq_r) + tmc_pkg::SUM_W'(sq_r);
    acc_wdata = (sum_full > tmc_pkg::SUM_W'(tmc_pkg::ACC_MAX))
              ? tmc_pkg::ACC_MAX : sum_full[tmc_pkg::ACC_W-1:0];
    // strict less: the earlier template keeps a tie
    better    = p2_v_r && last_r && (acc_wdata < best_r);
  end

  // ------------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    scnt_nxt  = scnt_r;
    gcnt_nxt  = gcnt_r;
    base_nxt  = base_r;
    unique case (state_r)
      tmc_pkg::ST_IDLE: begin
        if (cls_start) begin
          state_nxt = tmc_pkg::ST_RUN;
          cnt_nxt   = '0;
          scnt_nxt  = '0;
          gcnt_nxt  = '0;
          base_nxt  = chan_ok ? tmc_pkg::TA_W'(in_ch.channel_index) : '0;
        end
      end
      tmc_pkg::ST_RUN: begin
        cnt_nxt  = cnt_r + 1'b1;
        base_nxt = base_r + tmc_pkg::TA_W'(tmc_pkg::CHANNELS);
        if (scnt_r == tmc_pkg::SCNT_W'(tmc_pkg::TEMPLATES_PER_GESTURE - 1)) begin
          scnt_nxt = '0;
          gcnt_nxt = gcnt_r + 1'b1;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
        end
        if (cnt_r == tmc_pkg::TCNT_W'(tmc_pkg::NUM_TEMPLATES - 1)) begin
          state_nxt = tmc_pkg::ST_DRAIN;
        end
      end
      tmc_pkg::ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = last_r ? tmc_pkg::ST_EMIT : tmc_pkg::ST_IDLE;
        end
      end
      tmc_pkg::ST_EMIT: begin
        if (out_ld) begin
          state_nxt = tmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmc_pkg::ST_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      acc_vld_r   <= '0;
      out_valid_r <= 1'b0;
      thr_sq_r    <= tmc_pkg::THR_SQ_W'(tmc_pkg::THR_RESET * tmc_pkg::THR_RESET);
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= issue;
      p2_v_r  <= p1_v_r;
      if (out_ld) begin
        acc_vld_r <= '0;        // frame done: all sums back to zero
      end else if (p2_v_r) begin
        acc_vld_r[p2_t_r] <= 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        thr_sq_r <= tmc_pkg::THR_SQ_W'(cfg_wdata) * tmc_pkg::THR_SQ_W'(cfg_wdata);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    scnt_r <= scnt_nxt;
    gcnt_r <= gcnt_nxt;
    base_r <= base_nxt;
    if (cls_start) begin
      val_r    <= in_ch.sensor_value[tmc_pkg::SAMPLE_BITS-1:0];
      in_rng_r <= chan_ok;
      last_r   <= in_ch.last_channel;
      best_r   <= tmc_pkg::START_BEST_SQ;
      best_g_r <= '0;
      found_r  <= 1'b0;
    end else if (better) begin
      best_r   <= acc_wdata;
      best_g_r <= p2_g_r;
      found_r  <= 1'b1;
    end
    p1_t_r <= cnt_r;
    p1_g_r <= gcnt_r;
    p2_t_r <= p1_t_r;
    p2_g_r <= p1_g_r;
    sq_r   <= sq_nxt;
    accq_r <= accq_nxt;
    if (out_ld) begin
      out_matched_r <= found_r && (best_r < thr_sq_r);
      out_gid_r     <= (found_r && (best_r < thr_sq_r))
                     ? tmc_pkg::GESTURE_W'(best_g_r) : '0;
      out_best_r    <= best_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.gesture_id       = out_gid_r;
  assign out_ch.matched          = out_matched_r;
  assign out_ch.best_distance_sq = out_best_r;

`ifndef SYNTHESIS
  // Write-back only happens while a sample is being processed
  a_p2_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> (state_r == tmc_pkg::ST_RUN || state_r == tmc_pkg::ST_DRAIN))
    else $error("accumulator write-back outside a classify scan");

  // Only a last-channel sample leads to a result
  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmc_pkg::ST_EMIT) |-> last_r)
    else $error("result emitted for a sample that does not end the frame");

  // Accumulators are cleared once the result is registered
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (acc_vld_r == '0))
    else $error("accumulators not cleared at end of frame");

  // A match always lies below the squared threshold
  a_match_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> (out_best_r < thr_sq_r))
    else $error("match reported at or above threshold");
`endif

endmodule

`default_nettype wire

### design/tmc_ram.sv
// tmc_ram: generic simple dual-port RAM, one write port, one registered read.
// No dependencies.
`default_nettype none

module tmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                          clk,
  input  wire                                          we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire [WIDTH-1:0]                              wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
